@@ hw/rtl/ilid_pkg.sv @@
// Package for the indexed list core: widths, operation and status codes, cell command.
package ilid_pkg;

  localparam int DATA_W       = 32;
  localparam int POS_W        = 8;
  localparam int MODE_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int LEN_W        = 7;
  localparam int CAPACITY_DEF = 64;

  typedef enum logic [MODE_W-1:0] {
    MODE_READ = 3'd0,
    MODE_HEAD = 3'd1,
    MODE_TAIL = 3'd2,
    MODE_AT   = 3'd3,
    MODE_DEL  = 3'd4
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  // Command broadcast to every cell of the chain
  typedef struct packed {
    logic              ins;
    logic              del;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

@@ hw/rtl/ilid_in_if.sv @@
// Request channel: one list operation per transaction.
interface ilid_in_if
  import ilid_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [MODE_W-1:0]        mode;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output mode, output position, output value, input ready);
  modport sink   (input valid, input mode, input position, input value, output ready);
endinterface

@@ hw/rtl/ilid_out_if.sv @@
// Response channel: one result per operation.
interface ilid_out_if
  import ilid_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] read_value;
  logic [STATUS_W-1:0]      status;
  logic [LEN_W-1:0]         length;

  modport source (output valid, output read_value, output status, output length, input ready);
  modport sink   (input valid, input read_value, input status, input length, output ready);
endinterface

@@ hw/rtl/ilid_cell.sv @@
// One list cell: holds one element, shifts from a neighbor, loads, or holds.
module ilid_cell
  import ilid_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  cell_cmd_t         cmd,
  input  logic [DATA_W-1:0] left_data,
  input  logic [DATA_W-1:0] right_data,
  output logic [DATA_W-1:0] data,
  output logic [DATA_W-1:0] rd_data
);

  localparam logic [POS_W-1:0] IDX = POS_W'(INDEX);

  logic [DATA_W-1:0] data_next;

  // Pick shift-up, load, shift-down or hold
  always_comb begin
    data_next = data;
    if (cmd.ins) begin
      if (IDX > cmd.pos) begin
        data_next = left_data;
      end else if (IDX == cmd.pos) begin
        data_next = cmd.value;
      end
    end else if (cmd.del && (IDX >= cmd.pos)) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

  // Drive the read bus only when addressed
  assign rd_data = (IDX == cmd.pos) ? data : '0;

endmodule

@@ hw/rtl/indexed_list_insert_delete_core.sv @@
// Top level of the indexed list core: decode, chain of cells, result register.
//
//  Channel   Modport  Payload                          Direction
//  in_ch     sink     mode, position, value            operations in
//  out_ch    source   read_value, status, length       one result per operation out
//
// All cells shift, load or hold together on each accepted operation, and the
// result is registered at the same edge. A new transaction is taken while the result
// register is empty or being drained, so one operation per cycle is sustained.
// Reset (rst, synchronous) clears the element count and the result valid; cell
// contents stay undefined and are never read at or above the count.
// A stalled output holds its result and blocks further input until it is taken.
module indexed_list_insert_delete_core
  import ilid_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  ilid_in_if.sink    in_ch,
  ilid_out_if.source out_ch
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = POS_W + 1;
  localparam logic [CMP_W-1:0] CAP_EXT = CMP_W'(CAPACITY);

  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;
  logic              acc;
  cell_cmd_t         cmd;
  logic [CMP_W-1:0]  count_ext;
  logic [CMP_W-1:0]  pos_ext;
  logic [CMP_W-1:0]  ins_pos;
  logic              is_ins;
  logic [DATA_W-1:0] rd_bus;
  logic [DATA_W-1:0] rd_result;
  status_t           st_result;

  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [DATA_W-1:0] cell_rd   [CAPACITY];

  logic                     out_valid;
  logic signed [DATA_W-1:0] read_value;
  status_t                  status;
  logic [LEN_W-1:0]         length;

  // Accept when the result register is free or draining
  assign in_ch.ready = !rst && (!out_valid || out_ch.ready);
  assign acc         = in_ch.valid && in_ch.ready;

  assign count_ext = CMP_W'(count);
  assign pos_ext   = CMP_W'(in_ch.position);

  // Decode the operation into a cell command and a result
  always_comb begin
    cmd       = '0;
    cmd.pos   = in_ch.position;
    cmd.value = in_ch.value;
    rd_result = '1;
    st_result = ST_RANGE;
    count_next = count;
    is_ins    = 1'b0;
    ins_pos   = pos_ext;
    case (in_ch.mode)
      MODE_READ: begin
        if (pos_ext < count_ext) begin
          rd_result = rd_bus;
          st_result = ST_DONE;
        end
      end
      MODE_HEAD: begin
        is_ins  = 1'b1;
        ins_pos = '0;
      end
      MODE_TAIL: begin
        is_ins  = 1'b1;
        ins_pos = count_ext;
      end
      MODE_AT: begin
        is_ins  = 1'b1;
        ins_pos = pos_ext;
      end
      MODE_DEL: begin
        if (pos_ext < count_ext) begin
          cmd.del    = acc;
          st_result  = ST_DONE;
          count_next = count - CNT_W'(1);
        end
      end
      default: begin
        st_result = ST_RANGE;
      end
    endcase
    if (is_ins) begin
      cmd.pos = ins_pos[POS_W-1:0];
      if (ins_pos > count_ext) begin
        st_result = ST_RANGE;
      end else if (count_ext >= CAP_EXT) begin
        st_result = ST_FULL;
      end else begin
        cmd.ins    = acc;
        st_result  = ST_DONE;
        count_next = count + CNT_W'(1);
      end
    end
  end

  // Chain of cells, each fed by its neighbors
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_mid_r
      assign right_d = cell_data[i+1];
    end
    ilid_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[i]),
      .rd_data    (cell_rd[i])
    );
  end

  // Combine the gated read outputs of all cells
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // Advance the element count on each accepted transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (acc) begin
      count <= count_next;
    end
  end

  // Hold the result until the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (acc) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      read_value <= rd_result;
      status     <= st_result;
      length     <= LEN_W'(count_next);
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.read_value = read_value;
  assign out_ch.status     = status;
  assign out_ch.length     = length;

  // Count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(count) <= CAP_EXT)
    else $error("element count above capacity");

  // Count moves only with an accepted transaction
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (!acc && !rst) |=> $stable(count))
    else $error("element count changed without a transaction");

  // Every accepted transaction leaves a pending result
  a_result_valid: assert property (@(posedge clk) disable iff (rst)
    acc |=> out_valid)
    else $error("accepted transaction produced no result");

  // A refused insert only happens on a full list
  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_FULL) |-> (CMP_W'(count) == CAP_EXT))
    else $error("full status on a list that is not full");

endmodule

@@ verif/tb.sv @@
// Testbench for the indexed list core: random list operations checked against a local list model.
`timescale 1ns / 100ps

module tb
  import ilid_pkg::*;
();

  localparam int IDLE_PCT    = 36;
  localparam int STALL_LIMIT = 1000;
  localparam int DRAIN_WAIT  = 8;

  typedef struct {
    logic [MODE_W-1:0]        mode;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } list_op_t;

  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    status_t                  status;
    logic [LEN_W-1:0]         length;
  } list_result_t;

  logic clk;
  logic rst;

  ilid_in_if  in_ch ();
  ilid_out_if out_ch ();

  indexed_list_insert_delete_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  list_op_t     pending_ops[$];
  list_result_t expected_results[$];
  list_op_t     op_on_bus;

  // List model state
  logic signed [DATA_W-1:0] list_cells[0:CAPACITY_DEF-1];
  int                       list_len;

  int  mismatches;
  int  cycle_count;
  int  stall_cycles;
  int  gen_len;
  logic calm;

  // Clock and reset
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.mode      = '0;
    in_ch.position  = '0;
    in_ch.value     = '0;
    out_ch.ready    = 1'b0;
    list_len        = 0;
    mismatches      = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // Insert before a position, shifting later cells up
  function automatic status_t insert_cell(int pos, logic signed [DATA_W-1:0] val);
    int slot;
    if (pos > list_len) return ST_RANGE;
    if (list_len >= CAPACITY_DEF) return ST_FULL;
    for (slot = list_len; slot > pos; slot--) list_cells[slot] = list_cells[slot-1];
    list_cells[pos] = val;
    list_len++;
    return ST_DONE;
  endfunction

  // Apply one operation to the list model and return its result
  function automatic list_result_t apply_list_op(list_op_t op);
    list_result_t res;
    int slot;
    res.read_value = -1;
    res.status     = ST_RANGE;
    case (op.mode)
      MODE_READ: begin
        if (op.position < list_len) begin
          res.read_value = list_cells[op.position];
          res.status     = ST_DONE;
        end
      end
      MODE_HEAD: res.status = insert_cell(0, op.value);
      MODE_TAIL: res.status = insert_cell(list_len, op.value);
      MODE_AT:   res.status = insert_cell(int'(op.position), op.value);
      MODE_DEL: begin
        if (op.position < list_len) begin
          for (slot = op.position; slot < list_len - 1; slot++)
            list_cells[slot] = list_cells[slot+1];
          list_len--;
          res.status = ST_DONE;
        end
      end
      default: ;
    endcase
    res.length = LEN_W'(list_len);
    return res;
  endfunction

  task automatic push_op(logic [MODE_W-1:0] mode, logic [POS_W-1:0] pos,
                         logic signed [DATA_W-1:0] val);
    list_op_t op;
    op.mode     = mode;
    op.position = pos;
    op.value    = val;
    pending_ops.push_back(op);
  endtask

  // Random operation, mostly well formed for the current generator length
  task automatic push_random_op(int ins_pct, int del_pct);
    list_op_t op;
    int r;
    r = $urandom_range(99);
    op.value    = $urandom;
    op.position = POS_W'($urandom);
    if (r < 4) begin
      op.mode = MODE_W'($urandom_range(7));
    end else if (r < 4 + ins_pct) begin
      case ($urandom_range(2))
        0: op.mode = MODE_HEAD;
        1: op.mode = MODE_TAIL;
        default: begin
          op.mode = MODE_AT;
          if ($urandom_range(9) != 0) op.position = POS_W'($urandom_range(gen_len));
        end
      endcase
    end else begin
      op.mode = (r < 4 + ins_pct + del_pct) ? MODE_DEL : MODE_READ;
      if (gen_len > 0 && $urandom_range(9) != 0)
        op.position = POS_W'($urandom_range(gen_len - 1));
    end
    // Track the length to steer later positions
    if ((op.mode == MODE_HEAD || op.mode == MODE_TAIL ||
         (op.mode == MODE_AT && op.position <= gen_len)) && gen_len < CAPACITY_DEF)
      gen_len++;
    else if (op.mode == MODE_DEL && op.position < gen_len)
      gen_len--;
    pending_ops.push_back(op);
  endtask

  // Stimulus and end of run
  initial begin
    int phase;
    int n;
    // Directed: empty list, extremes, every operation, range cases, unused modes
    push_op(MODE_READ, 8'd0, 32'sd5);
    push_op(MODE_DEL, 8'd0, 32'sd0);
    push_op(MODE_AT, 8'd1, 32'sd7);
    push_op(MODE_HEAD, 8'd200, 32'sh8000_0000);
    push_op(MODE_TAIL, 8'd255, 32'sh7fff_ffff);
    push_op(MODE_AT, 8'd1, -32'sd1);
    push_op(MODE_AT, 8'd3, 32'sh5a5a_a5a5);
    push_op(MODE_AT, 8'd5, 32'sd1);
    push_op(MODE_READ, 8'd0, 32'sd0);
    push_op(MODE_READ, 8'd1, 32'sd0);
    push_op(MODE_READ, 8'd2, 32'sd0);
    push_op(MODE_READ, 8'd3, 32'sd0);
    push_op(MODE_READ, 8'd4, 32'sd0);
    push_op(MODE_READ, 8'd255, 32'sd0);
    push_op(MODE_AT, 8'd255, 32'sd9);
    push_op(MODE_DEL, 8'd255, 32'sd0);
    push_op(MODE_DEL, 8'd1, 32'sd0);
    push_op(3'd5, 8'd0, 32'sd3);
    push_op(3'd6, 8'd255, -32'sd1);
    push_op(3'd7, 8'd170, 32'sh5555_5555);
    push_op(MODE_READ, 8'd1, 32'sd0);
    push_op(MODE_DEL, 8'd2, 32'sd0);
    push_op(MODE_DEL, 8'd0, 32'sd0);
    push_op(MODE_DEL, 8'd0, 32'sd0);
    gen_len = 0;
    // Random: insert-heavy, mixed and delete-heavy phases in turn, to fill and drain the list
    for (phase = 0; phase < 11; phase++) begin
      for (n = 0; n < 100; n++) begin
        case (phase % 3)
          0: push_random_op(70, 10);
          1: push_random_op(35, 35);
          default: push_random_op(10, 70);
        endcase
      end
    end

    do @(negedge clk);
    while (pending_ops.size() != 0 || in_ch.valid || expected_results.size() != 0);
    repeat (DRAIN_WAIT) @(negedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Idle pattern: random gaps except in one calm stretch
  always @(posedge clk) begin
    cycle_count <= rst ? 0 : cycle_count + 1;
  end
  assign calm = (cycle_count >= 1200) && (cycle_count < 1800);

  // Driver: predict on acceptance, then load the next operation
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_results.push_back(apply_list_op(op_on_bus));
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_ops.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          op_on_bus = pending_ops.pop_front();
          in_ch.mode     <= op_on_bus.mode;
          in_ch.position <= op_on_bus.position;
          in_ch.value    <= op_on_bus.value;
          in_ch.valid    <= 1'b1;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    list_result_t exp_res;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result read_value %0d status %0d length %0d",
                   $time, out_ch.read_value, out_ch.status, out_ch.length);
          mismatches++;
        end else begin
          exp_res = expected_results.pop_front();
          if (out_ch.read_value !== exp_res.read_value) begin
            $display("%0t: read_value expected %0d actual %0d",
                     $time, exp_res.read_value, out_ch.read_value);
            mismatches++;
          end
          if (out_ch.status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, exp_res.status, out_ch.status);
            mismatches++;
          end
          if (out_ch.length !== exp_res.length) begin
            $display("%0t: length expected %0d actual %0d",
                     $time, exp_res.length, out_ch.length);
            mismatches++;
          end
        end
      end
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Watchdog: end the run when no transaction moves for too long
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("status: fail");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial stall_cycles = 0;
  initial cycle_count = 0;

endmodule
